// File: rtl/core/kscp_pkg.sv
// Shared types, constants and character helpers for the keyword substitution cipher.
`default_nettype none

package kscp_pkg;

    localparam int ALPHABET_SIZE = 27;
    localparam int SYM_W         = $clog2(ALPHABET_SIZE);
    localparam int POS_W         = $clog2(ALPHABET_SIZE + 1);

    localparam logic [7:0] CH_SPACE   = 8'h20;  // ' '
    localparam logic [7:0] CH_UP_BASE = 8'h40;  // '@', one below 'A'
    localparam logic [7:0] CH_LO_BASE = 8'h60;  // '`', one below 'a'
    localparam logic [7:0] CH_NONE    = 8'h00;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_KEY   = 2'd1,
        OP_ENC   = 2'd2,
        OP_DEC   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_DUP     = 2'd2,
        ST_LONG    = 2'd3
    } t_status;

    typedef struct packed {
        logic             ok;
        logic [SYM_W-1:0] sym;
    } t_sym;

    // Table port request: two forward reads, one inverse read, one write per table.
    typedef struct packed {
        logic             clear;
        logic [SYM_W-1:0] fwd_raddr0;
        logic [SYM_W-1:0] fwd_raddr1;
        logic [SYM_W-1:0] inv_raddr;
        logic             fwd_we;
        logic [SYM_W-1:0] fwd_waddr;
        logic [SYM_W-1:0] fwd_wdata;
        logic             inv_we;
        logic [SYM_W-1:0] inv_waddr;
        logic [SYM_W-1:0] inv_wdata;
    } t_tbl_req;

    typedef struct packed {
        logic [SYM_W-1:0] fwd_rd0;
        logic [SYM_W-1:0] fwd_rd1;
        logic [SYM_W-1:0] inv_rd;
    } t_tbl_rsp;

    // Space or a-z; symbol is zero when the character is rejected.
    function automatic t_sym lower_sym(input logic [7:0] c);
        t_sym r;
        r = '0;
        if (c == CH_SPACE) begin
            r.ok = 1'b1;
        end else if (c inside {[8'h61:8'h7A]}) begin
            r.ok  = 1'b1;
            r.sym = SYM_W'(c - CH_LO_BASE);
        end
        return r;
    endfunction

    // Space or A-Z; symbol is zero when the character is rejected.
    function automatic t_sym upper_sym(input logic [7:0] c);
        t_sym r;
        r = '0;
        if (c == CH_SPACE) begin
            r.ok = 1'b1;
        end else if (c inside {[8'h41:8'h5A]}) begin
            r.ok  = 1'b1;
            r.sym = SYM_W'(c - CH_UP_BASE);
        end
        return r;
    endfunction

    // Symbol to character; out-of-range symbols fold to space.
    function automatic logic [7:0] sym_to_char(input logic [SYM_W-1:0] v,
                                               input logic [7:0] base);
        logic [7:0] r;
        if (v == '0 || 32'(v) >= ALPHABET_SIZE) begin
            r = CH_SPACE;
        end else begin
            r = base + 8'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/kscp_tables.sv
// Forward and inverse permutation memories with per-entry valid bits (identity when unwritten).
`default_nettype none

module kscp_tables (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kscp_pkg::t_tbl_req i_req,
    output kscp_pkg::t_tbl_rsp o_rsp
);

    localparam int N = kscp_pkg::ALPHABET_SIZE;
    localparam int W = kscp_pkg::SYM_W;

    logic [W-1:0] r_fwd_mem [N];
    logic [W-1:0] r_inv_mem [N];
    logic [N-1:0] r_fwd_vld;
    logic [N-1:0] r_inv_vld;

    logic [W-1:0] r_fwd_d0, r_fwd_d1, r_inv_d;
    logic [W-1:0] r_fwd_a0, r_fwd_a1, r_inv_a;
    logic         r_fwd_v0, r_fwd_v1, r_inv_v;

    always_ff @(posedge i_clk) begin
        if (i_req.fwd_we) begin
            r_fwd_mem[i_req.fwd_waddr] <= i_req.fwd_wdata;
        end
        if (i_req.inv_we) begin
            r_inv_mem[i_req.inv_waddr] <= i_req.inv_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_d0 <= r_fwd_mem[i_req.fwd_raddr0];
        r_fwd_d1 <= r_fwd_mem[i_req.fwd_raddr1];
        r_inv_d  <= r_inv_mem[i_req.inv_raddr];
        r_fwd_v0 <= r_fwd_vld[i_req.fwd_raddr0];
        r_fwd_v1 <= r_fwd_vld[i_req.fwd_raddr1];
        r_inv_v  <= r_inv_vld[i_req.inv_raddr];
        r_fwd_a0 <= i_req.fwd_raddr0;
        r_fwd_a1 <= i_req.fwd_raddr1;
        r_inv_a  <= i_req.inv_raddr;
    end

    // Drop all valid bits on reset or clear: every entry then reads as its own index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            r_fwd_vld <= '0;
            r_inv_vld <= '0;
        end else begin
            if (i_req.fwd_we) begin
                r_fwd_vld[i_req.fwd_waddr] <= 1'b1;
            end
            if (i_req.inv_we) begin
                r_inv_vld[i_req.inv_waddr] <= 1'b1;
            end
        end
    end

    assign o_rsp.fwd_rd0 = r_fwd_v0 ? r_fwd_d0 : r_fwd_a0;
    assign o_rsp.fwd_rd1 = r_fwd_v1 ? r_fwd_d1 : r_fwd_a1;
    assign o_rsp.inv_rd  = r_inv_v  ? r_inv_d  : r_inv_a;

endmodule

`default_nettype wire

// File: rtl/core/keyword_substitution_cipher_top.sv
// Top level of the keyword substitution cipher: request sequencer, key state and result register.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+-------------------------------
//  request | in        | i_in_valid / o_in_ready    | i_operation[1:0], i_char_code[7:0]
//  result  | out       | o_out_valid / i_out_ready  | o_char_out[7:0], o_status[1:0]
//
//  Steps: a request passes through accept + table read, lookup and result load; a
//  key character that passes its checks adds a swap step, since each table has one write
//  port and the swap writes two entries of each table.
//  Reset: valid bits in the tables make every unwritten entry read as identity, so no
//  clearing pass is needed; the clear operation drops the valid bits as it is accepted.
//  Stalls: a finished result waits in the output register while the next request is
//  accepted; the sequencer holds in its load step only if that register is still full.
`default_nettype none

module keyword_substitution_cipher_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_char_code,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_char_out,
    output logic [1:0] o_status
);

    localparam int W  = kscp_pkg::SYM_W;
    localparam int PW = kscp_pkg::POS_W;
    localparam int N  = kscp_pkg::ALPHABET_SIZE;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_SWAP = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    kscp_pkg::t_op      r_op;
    kscp_pkg::t_status  r_status, n_status;
    logic [W-1:0]       r_sym;
    logic [W-1:0]       r_a;
    logic [PW-1:0]      r_key_pos;
    logic [N-1:0]       r_seen;
    logic [7:0]         r_res_char;
    logic               r_out_valid;
    logic [7:0]         r_out_char;
    kscp_pkg::t_status  r_out_status;

    kscp_pkg::t_tbl_req tbl_req;
    kscp_pkg::t_tbl_rsp tbl_rsp;
    kscp_pkg::t_op      in_op;
    kscp_pkg::t_sym     lo, up;
    logic               in_acc;
    logic               key_go;
    logic               out_load;
    logic [W-1:0]       pos_sym;
    logic [7:0]         look_char;

    assign in_op      = kscp_pkg::t_op'(i_operation);
    assign lo         = kscp_pkg::lower_sym(i_char_code);
    assign up         = kscp_pkg::upper_sym(i_char_code);
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign key_go     = (r_op == kscp_pkg::OP_KEY) && (r_status == kscp_pkg::ST_OK);
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    // Position is only used as an address while it is below the alphabet size.
    assign pos_sym    = (r_key_pos < PW'(N)) ? r_key_pos[W-1:0] : '0;

    kscp_tables u_tables (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_rsp   (tbl_rsp)
    );

    // Check order on a key character: invalid, then too long, then duplicate.
    always_comb begin
        n_status = kscp_pkg::ST_OK;
        case (in_op)
            kscp_pkg::OP_CLEAR: n_status = kscp_pkg::ST_OK;
            kscp_pkg::OP_KEY: begin
                if (!lo.ok) begin
                    n_status = kscp_pkg::ST_INVALID;
                end else if (r_key_pos >= PW'(N)) begin
                    n_status = kscp_pkg::ST_LONG;
                end else if (r_seen[lo.sym]) begin
                    n_status = kscp_pkg::ST_DUP;
                end
            end
            kscp_pkg::OP_ENC: n_status = lo.ok ? kscp_pkg::ST_OK : kscp_pkg::ST_INVALID;
            kscp_pkg::OP_DEC: n_status = up.ok ? kscp_pkg::ST_OK : kscp_pkg::ST_INVALID;
            default:          n_status = kscp_pkg::ST_INVALID;
        endcase
    end

    // Lookup result, valid in the cycle after the read was issued.
    always_comb begin
        look_char = kscp_pkg::CH_NONE;
        if (r_status == kscp_pkg::ST_OK) begin
            case (r_op)
                kscp_pkg::OP_ENC:
                    look_char = kscp_pkg::sym_to_char(tbl_rsp.fwd_rd0, kscp_pkg::CH_UP_BASE);
                kscp_pkg::OP_DEC:
                    look_char = kscp_pkg::sym_to_char(tbl_rsp.inv_rd, kscp_pkg::CH_LO_BASE);
                default:
                    look_char = kscp_pkg::CH_NONE;
            endcase
        end
    end

    // Sequencer and table port control. Reads are issued from the request lines and the
    // key position every cycle; only those captured at the accept edge are used in the lookup step.
    // The swap: with a = fwd[s] and b = fwd[p], write fwd[s]=b, inv[b]=s, then
    // fwd[p]=a, inv[a]=p, which keeps the inverse exact without reading it.
    always_comb begin
        n_state            = r_state;
        tbl_req            = '0;
        tbl_req.clear      = in_acc && (in_op == kscp_pkg::OP_CLEAR);
        tbl_req.fwd_raddr0 = lo.sym;
        tbl_req.fwd_raddr1 = pos_sym;
        tbl_req.inv_raddr  = up.sym;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (key_go) begin
                    tbl_req.fwd_we    = 1'b1;
                    tbl_req.fwd_waddr = r_sym;
                    tbl_req.fwd_wdata = tbl_rsp.fwd_rd1;
                    tbl_req.inv_we    = 1'b1;
                    tbl_req.inv_waddr = tbl_rsp.fwd_rd1;
                    tbl_req.inv_wdata = r_sym;
                    n_state           = S_SWAP;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SWAP: begin
                tbl_req.fwd_we    = 1'b1;
                tbl_req.fwd_waddr = pos_sym;
                tbl_req.fwd_wdata = r_a;
                tbl_req.inv_we    = 1'b1;
                tbl_req.inv_waddr = r_a;
                tbl_req.inv_wdata = pos_sym;
                n_state           = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Key state: clear on the clear request, advance with the second swap write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || tbl_req.clear) begin
            r_key_pos <= '0;
            r_seen    <= '0;
        end else if (r_state == S_SWAP) begin
            r_key_pos      <= r_key_pos + PW'(1);
            r_seen[r_sym]  <= 1'b1;
        end
    end

    // Request payload and intermediate values.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= in_op;
            r_status <= n_status;
            r_sym    <= (in_op == kscp_pkg::OP_DEC) ? up.sym : lo.sym;
        end
        if (r_state == S_LOOK) begin
            r_a        <= tbl_rsp.fwd_rd0;
            r_res_char <= look_char;
        end
    end

    // Output register: load on the last step, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_char   <= r_res_char;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_char_out  = r_out_char;
    assign o_status    = r_out_status;

    // Every key character that passes its checks claims exactly one new letter and one position.
    a_seen_matches_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_seen) == 32'(r_key_pos))
        else $error("seen map population differs from key position");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_pos <= PW'(N))
        else $error("key position beyond alphabet size");

    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_LOOK))
        else $error("accepted request did not reach lookup");

    a_write_only_in_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tbl_req.fwd_we || tbl_req.inv_we) |-> (r_state == S_LOOK || r_state == S_SWAP))
        else $error("table written outside the swap steps");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result appeared without a load step");

endmodule

`default_nettype wire

// File: verif/tb_keyword_substitution_cipher_top.sv
// Self-checking testbench for the keyword substitution cipher top level.
module tb_keyword_substitution_cipher_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Number of random requests after the directed table.
    localparam int RANDOM_REQUESTS = 1600;
    // Cycles the receiver holds off during a pressure burst.
    localparam int HOLD_OFF_CYCLES = 300;
    // Cycles to wait after the last result for anything stray to show up.
    localparam int DRAIN_CYCLES    = 20;
    // Report only this many mismatches in detail.
    localparam int MAX_REPORTS     = 10;

    // One result as the block returns it.
    typedef struct packed {
        logic [7:0]        ch;
        kscp_pkg::t_status st;
    } t_cipher_out;

    // One row of the directed stimulus table; known rows carry a typed result.
    typedef struct packed {
        kscp_pkg::t_op     op;
        logic [7:0]        ch;
        logic              known;
        logic [7:0]        exp_ch;
        kscp_pkg::t_status exp_st;
    } t_dir_row;

    localparam int DIR_ROWS = 25;

    // Directed requests: identity after reset, the character range edges,
    // invalid characters on key, encrypt and decrypt, duplicate key letter, and
    // clear with a junk character.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{kscp_pkg::OP_ENC,   "a",   1'b1, "A",               kscp_pkg::ST_OK},
        '{kscp_pkg::OP_ENC,   " ",   1'b1, " ",               kscp_pkg::ST_OK},
        '{kscp_pkg::OP_ENC,   "z",   1'b1, "Z",               kscp_pkg::ST_OK},
        '{kscp_pkg::OP_DEC,   "Z",   1'b1, "z",               kscp_pkg::ST_OK},
        '{kscp_pkg::OP_DEC,   " ",   1'b1, " ",               kscp_pkg::ST_OK},
        '{kscp_pkg::OP_DEC,   "A",   1'b1, "a",               kscp_pkg::ST_OK},
        '{kscp_pkg::OP_DEC,   "a",   1'b1, kscp_pkg::CH_NONE, kscp_pkg::ST_INVALID},
        '{kscp_pkg::OP_ENC,   "A",   1'b1, kscp_pkg::CH_NONE, kscp_pkg::ST_INVALID},
        '{kscp_pkg::OP_ENC,   8'h00, 1'b1, kscp_pkg::CH_NONE, kscp_pkg::ST_INVALID},
        '{kscp_pkg::OP_KEY,   8'hFF, 1'b1, kscp_pkg::CH_NONE, kscp_pkg::ST_INVALID},
        '{kscp_pkg::OP_ENC,   8'h7B, 1'b1, kscp_pkg::CH_NONE, kscp_pkg::ST_INVALID},
        '{kscp_pkg::OP_DEC,   8'h40, 1'b1, kscp_pkg::CH_NONE, kscp_pkg::ST_INVALID},
        '{kscp_pkg::OP_ENC,   8'h60, 1'b1, kscp_pkg::CH_NONE, kscp_pkg::ST_INVALID},
        '{kscp_pkg::OP_DEC,   8'h5B, 1'b1, kscp_pkg::CH_NONE, kscp_pkg::ST_INVALID},
        '{kscp_pkg::OP_KEY,   "k",   1'b1, kscp_pkg::CH_NONE, kscp_pkg::ST_OK},
        '{kscp_pkg::OP_KEY,   "e",   1'b1, kscp_pkg::CH_NONE, kscp_pkg::ST_OK},
        '{kscp_pkg::OP_KEY,   "k",   1'b1, kscp_pkg::CH_NONE, kscp_pkg::ST_DUP},
        '{kscp_pkg::OP_ENC,   "a",   1'b0, kscp_pkg::CH_NONE, kscp_pkg::ST_OK},
        '{kscp_pkg::OP_ENC,   "k",   1'b0, kscp_pkg::CH_NONE, kscp_pkg::ST_OK},
        '{kscp_pkg::OP_DEC,   "K",   1'b0, kscp_pkg::CH_NONE, kscp_pkg::ST_OK},
        '{kscp_pkg::OP_DEC,   "A",   1'b0, kscp_pkg::CH_NONE, kscp_pkg::ST_OK},
        '{kscp_pkg::OP_KEY,   " ",   1'b1, kscp_pkg::CH_NONE, kscp_pkg::ST_OK},
        '{kscp_pkg::OP_ENC,   " ",   1'b0, kscp_pkg::CH_NONE, kscp_pkg::ST_OK},
        '{kscp_pkg::OP_CLEAR, 8'hA5, 1'b1, kscp_pkg::CH_NONE, kscp_pkg::ST_OK},
        '{kscp_pkg::OP_ENC,   "k",   1'b1, "K",               kscp_pkg::ST_OK}
    };

    // Clock, reset and block ports; every input is known from time zero.
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [1:0] i_operation = kscp_pkg::OP_CLEAR;
    logic [7:0] i_char_code = kscp_pkg::CH_NONE;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_char_out;
    logic [1:0] o_status;

    // Cipher state as predicted: forward and inverse permutation, keyword
    // position and the letters already used in the key.
    logic [4:0]  fwd_map [kscp_pkg::ALPHABET_SIZE];
    logic [4:0]  inv_map [kscp_pkg::ALPHABET_SIZE];
    logic [4:0]  key_pos;
    logic [26:0] used_syms;

    // Results predicted for accepted requests, oldest first.
    t_cipher_out pending_results [$];

    // Run bookkeeping.
    int  fail_count    = 0;
    int  checked_count = 0;
    int  error_status_count = 0;
    int  op_count [4]  = '{0, 0, 0, 0};
    bit  no_gap_mode   = 1'b0;
    bit  hold_request  = 1'b0;

    keyword_substitution_cipher_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_char_code (i_char_code),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_char_out  (o_char_out),
        .o_status    (o_status)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Restore identity tables, zero position, no letters used.
    function automatic void clear_cipher_state();
        for (int i = 0; i < kscp_pkg::ALPHABET_SIZE; i++) begin
            fwd_map[i] = 5'(i);
            inv_map[i] = 5'(i);
        end
        key_pos   = '0;
        used_syms = '0;
    endfunction

    // Character for a symbol: space for zero, base plus symbol otherwise.
    function automatic logic [7:0] sym_char(input int sym, input logic [7:0] base);
        return (sym == 0) ? kscp_pkg::CH_SPACE : base + 8'(sym);
    endfunction

    // Work out the result of one request and advance the predicted key state.
    function automatic t_cipher_out predict_cipher(input kscp_pkg::t_op op,
                                                   input logic [7:0] ch);
        t_cipher_out res;
        bit          lo_ok;
        bit          up_ok;
        int          lo_sym;
        int          up_sym;
        logic [4:0]  a;
        logic [4:0]  b;
        logic [4:0]  t;
        res    = '{ch: kscp_pkg::CH_NONE, st: kscp_pkg::ST_OK};
        lo_ok  = (ch == kscp_pkg::CH_SPACE) || (ch >= "a" && ch <= "z");
        up_ok  = (ch == kscp_pkg::CH_SPACE) || (ch >= "A" && ch <= "Z");
        lo_sym = (ch == kscp_pkg::CH_SPACE) ? 0 : int'(ch) - int'(kscp_pkg::CH_LO_BASE);
        up_sym = (ch == kscp_pkg::CH_SPACE) ? 0 : int'(ch) - int'(kscp_pkg::CH_UP_BASE);
        case (op)
            kscp_pkg::OP_CLEAR: begin
                clear_cipher_state();
            end
            kscp_pkg::OP_KEY: begin
                // Check order: invalid, then too long, then duplicate.
                if (!lo_ok) begin
                    res.st = kscp_pkg::ST_INVALID;
                end else if (key_pos >= kscp_pkg::ALPHABET_SIZE) begin
                    res.st = kscp_pkg::ST_LONG;
                end else if (used_syms[lo_sym]) begin
                    res.st = kscp_pkg::ST_DUP;
                end else begin
                    // Swap forward entries at the letter and at the position,
                    // then mirror the swap in the inverse table.
                    a = fwd_map[lo_sym];
                    b = fwd_map[key_pos];
                    fwd_map[lo_sym]  = b;
                    fwd_map[key_pos] = a;
                    t          = inv_map[a];
                    inv_map[a] = inv_map[b];
                    inv_map[b] = t;
                    used_syms[lo_sym] = 1'b1;
                    key_pos = key_pos + 5'd1;
                end
            end
            kscp_pkg::OP_ENC: begin
                if (!lo_ok) begin
                    res.st = kscp_pkg::ST_INVALID;
                end else begin
                    res.ch = sym_char(int'(fwd_map[lo_sym]), kscp_pkg::CH_UP_BASE);
                end
            end
            default: begin
                if (!up_ok) begin
                    res.st = kscp_pkg::ST_INVALID;
                end else begin
                    res.ch = sym_char(int'(inv_map[up_sym]), kscp_pkg::CH_LO_BASE);
                end
            end
        endcase
        return res;
    endfunction

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one request, hold it until accepted, then record its result.
    // Valid is lowered only when a gap follows, so it never drops and
    // rises in the same step.
    task automatic send_request(input kscp_pkg::t_op op, input logic [7:0] ch,
                                input bit known, input t_cipher_out typed);
        int          gap;
        t_cipher_out pred;
        gap = no_gap_mode ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_char_code <= ch;
        do @(posedge i_clk); while (!o_in_ready);
        // Accepted at this edge: the predictor always runs to keep its state,
        // but a typed row supplies its own expected result.
        pred = predict_cipher(op, ch);
        pending_results.insert(pending_results.size(), known ? typed : pred);
        op_count[op]++;
    endtask

    // Hold the sender until every outstanding result has come back; drop
    // valid first so the last request is not offered again.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Stimulus: reset, directed table, then random key and text sequences.
    initial begin
        int             rand_sent;
        int             key_len;
        int             text_len;
        int             sym_order [kscp_pkg::ALPHABET_SIZE];
        int             j;
        int             tmp;
        int             r;
        int             pick;
        kscp_pkg::t_op  op;
        logic [7:0]     ch;
        bit             drained;
        bit             second_hold;
        rand_sent   = 0;
        drained     = 1'b0;
        second_hold = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        clear_cipher_state();

        // Walk the directed table.
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_request(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].known,
                         '{ch: dir_rows[i].exp_ch, st: dir_rows[i].exp_st});
        end

        // Ask the receiver for a long hold-off while requests keep coming.
        hold_request = 1'b1;

        while (rand_sent < RANDOM_REQUESTS) begin
            no_gap_mode = ($urandom_range(0, 4) == 0);

            // Once midway: pause until the block has returned everything.
            if (!drained && rand_sent >= RANDOM_REQUESTS / 2) begin
                drained = 1'b1;
                wait_for_drain();
            end
            // A second hold-off late in the run.
            if (!second_hold && rand_sent >= (RANDOM_REQUESTS * 3) / 4) begin
                second_hold  = 1'b1;
                hold_request = 1'b1;
            end

            r = $urandom_range(0, 99);
            if (r < 70) begin
                // Well-formed sequence: usually a clear, then a keyword, then text.
                if ($urandom_range(0, 4) != 0) begin
                    send_request(kscp_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 1'b0, '0);
                    rand_sent++;
                end
                for (int i = 0; i < kscp_pkg::ALPHABET_SIZE; i++) sym_order[i] = i;
                for (int i = kscp_pkg::ALPHABET_SIZE - 1; i > 0; i--) begin
                    j            = $urandom_range(0, i);
                    tmp          = sym_order[i];
                    sym_order[i] = sym_order[j];
                    sym_order[j] = tmp;
                end
                // Mostly short keys; some run past the full alphabet.
                key_len = ($urandom_range(0, 99) < 15) ? $urandom_range(27, 32)
                                                       : $urandom_range(0, 12);
                for (int k = 0; k < key_len; k++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 5 && k > 0) begin
                        // Repeat a letter from earlier in this key's shuffled order.
                        ch = sym_char(sym_order[$urandom_range(0, (k > 26) ? 26 : k - 1)],
                                      kscp_pkg::CH_LO_BASE);
                    end else if (pick < 10) begin
                        ch = 8'($urandom_range(0, 255));
                    end else if (k < kscp_pkg::ALPHABET_SIZE) begin
                        ch = sym_char(sym_order[k], kscp_pkg::CH_LO_BASE);
                    end else begin
                        ch = sym_char($urandom_range(0, 26), kscp_pkg::CH_LO_BASE);
                    end
                    send_request(kscp_pkg::OP_KEY, ch, 1'b0, '0);
                    rand_sent++;
                end
                text_len = $urandom_range(5, 40);
                for (int k = 0; k < text_len; k++) begin
                    op = $urandom_range(0, 1) ? kscp_pkg::OP_ENC : kscp_pkg::OP_DEC;
                    if ($urandom_range(0, 9) == 0) begin
                        ch = 8'($urandom_range(0, 255));
                    end else begin
                        ch = sym_char($urandom_range(0, 26),
                                      (op == kscp_pkg::OP_ENC) ? kscp_pkg::CH_LO_BASE
                                                               : kscp_pkg::CH_UP_BASE);
                    end
                    send_request(op, ch, 1'b0, '0);
                    rand_sent++;
                end
            end else begin
                // Noise: random operation and raw byte, clears kept rare.
                text_len = $urandom_range(1, 20);
                for (int k = 0; k < text_len; k++) begin
                    op = ($urandom_range(0, 19) == 0) ? kscp_pkg::OP_CLEAR
                                                      : kscp_pkg::t_op'($urandom_range(1, 3));
                    send_request(op, 8'($urandom_range(0, 255)), 1'b0, '0);
                    rand_sent++;
                end
            end
        end

        i_in_valid <= 1'b0;
        wait_for_drain();
        // Give any stray result time to appear.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d clear, %0d key, %0d encrypt and %0d decrypt requests.",
                 op_count[kscp_pkg::OP_CLEAR], op_count[kscp_pkg::OP_KEY],
                 op_count[kscp_pkg::OP_ENC], op_count[kscp_pkg::OP_DEC]);
        $display("Checked %0d results, %0d of them carrying an error status.",
                 checked_count, error_status_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Receiver: ready in runs with random gaps; on request, hold off for a
    // long stretch so the result register fills and input stalls.
    initial begin
        int run;
        int gap;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 8);
                repeat (run) @(posedge i_clk);
                gap = pick_gap();
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // Result checker: compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_cipher_out exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                if (fail_count < MAX_REPORTS) begin
                    $display("%0t: result with nothing pending: char %h status %0d",
                             $realtime, o_char_out, o_status);
                end
                fail_count++;
            end else begin
                exp_res = pending_results.pop_front();
                checked_count++;
                if (exp_res.st != kscp_pkg::ST_OK) error_status_count++;
                if (o_char_out !== exp_res.ch || o_status !== exp_res.st) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display({"%0t: mismatch: expected char %h status %0d,",
                                  " got char %h status %0d"},
                                 $realtime, exp_res.ch, exp_res.st, o_char_out, o_status);
                    end
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial begin
        #10_000_000;
        $display("Run timed out with %0d results pending.", pending_results.size());
        $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/kscp_pkg.sv
rtl/core/kscp_tables.sv
rtl/core/keyword_substitution_cipher_top.sv
verif/tb_keyword_substitution_cipher_top.sv
